/* rtl/sbsa_pkg.sv */
package sbsa_pkg;

    // bitmap word geometry
    localparam int WORD_W = 32;
    localparam int OFF_W = 5;

    // defaults
    localparam int SLOT_COUNT_DEF = 128;
    localparam logic [7:0] CLUSTER_RESET = 8'd16;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;
    localparam logic [1:0] REQ_NOP = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] slot_index;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] granted_slot;
        logic [7:0] free_slots;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       res_load;
        logic [1:0] res_code;
        logic       start_idx;
        logic       start_cluster;
        logic       start_fresh;
        logic       cluster_fail;
        logic       rd_en;
        logic       commit_free;
        logic       commit_alloc;
        logic       next_word;
        logic       push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       range_bad;
        logic       count_zero;
        logic       cluster_ok;
        logic       bit_used;
        logic       hit;
        logic       last_word;
        logic       is_cluster;
        logic       out_free;
    } sts_t;

endpackage

/* rtl/sbsa_ram.sv */
module sbsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sbsa_ctrl.sv */
module sbsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sbsa_pkg::sts_t sts,
    output sbsa_pkg::cmd_t cmd
);

    import sbsa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;
    localparam logic [2:0] S_CHK = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                case (sts.req_type) inside
                    REQ_ALLOC: begin
                        if (sts.count_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_FULL;
                            state_next = S_PUSH;
                        end else if (sts.cluster_ok) begin
                            cmd.start_cluster = 1'b1;
                            state_next = S_RD;
                        end else begin
                            cmd.start_fresh = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    REQ_FREE, REQ_CHECK: begin
                        if (sts.range_bad) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_RANGE;
                            state_next = S_PUSH;
                        end else begin
                            cmd.start_idx = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_OK;
                        state_next = S_PUSH;
                    end
                endcase
            end
            S_RD: begin
                cmd.rd_en = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (sts.req_type == REQ_ALLOC) begin
                    if (sts.hit) begin
                        cmd.commit_alloc = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_OK;
                        state_next = S_PUSH;
                    end else if (!sts.last_word) begin
                        cmd.next_word = 1'b1;
                        state_next = S_RD;
                    end else if (sts.is_cluster) begin
                        // cluster scan ran off the end, rescan from slot zero
                        cmd.cluster_fail = 1'b1;
                        cmd.start_fresh = 1'b1;
                        state_next = S_RD;
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_FULL;
                        state_next = S_PUSH;
                    end
                end else begin
                    cmd.res_load = 1'b1;
                    state_next = S_PUSH;
                    if (!sts.bit_used) begin
                        cmd.res_code = ST_UNUSED;
                    end else begin
                        cmd.res_code = ST_OK;
                        cmd.commit_free = (sts.req_type == REQ_FREE);
                    end
                end
            end
            S_PUSH: begin
                if (sts.out_free) begin
                    cmd.push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sbsa_dp.sv */
module sbsa_dp #(
    parameter int SLOT_COUNT = sbsa_pkg::SLOT_COUNT_DEF,
    localparam int NW = (SLOT_COUNT + sbsa_pkg::WORD_W - 1) / sbsa_pkg::WORD_W,
    localparam int PW = (NW > 1) ? $clog2(NW) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbsa_pkg::in_beat_t          s_data,
    input  logic                        cfg_wr_en,
    input  logic [7:0]                  cfg_wr_data,
    input  sbsa_pkg::cmd_t              cmd,
    output sbsa_pkg::sts_t              sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sbsa_pkg::out_beat_t         m_data,
    output logic                        ram_we,
    output logic [PW-1:0]               ram_waddr,
    output logic [sbsa_pkg::WORD_W-1:0] ram_wdata,
    output logic                        ram_re,
    output logic [PW-1:0]               ram_raddr,
    input  logic [sbsa_pkg::WORD_W-1:0] ram_rdata
);

    import sbsa_pkg::*;

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int LAST_BITS = SLOT_COUNT - (NW - 1) * WORD_W;
    localparam logic [WORD_W-1:0] PAD_MASK =
        (LAST_BITS == WORD_W) ? '0 : ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    logic [1:0]        req_type_reg;
    logic [7:0]        slot_index_reg;
    logic [PW-1:0]     ptr_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              cluster_reg;
    logic              first_reg;
    logic              row_valid_q_reg;
    logic [NW-1:0]     row_valid_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     cursor_reg;
    logic [7:0]        budget_reg;
    logic [7:0]        length_reg;
    logic [1:0]        res_status_reg;
    logic [6:0]        res_slot_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [WORD_W-1:0] w_raw;
    logic [WORD_W-1:0] eff;
    logic [WORD_W-1:0] lo_mask;
    logic [OFF_W-1:0]  ff;
    logic [OFF_W-1:0]  idx_off;
    logic [CW-1:0]     slot_w;
    logic              last_word;

    // word as stored, unwritten rows read as all free
    assign w_raw = row_valid_q_reg ? ram_rdata : '0;
    assign idx_off = slot_index_reg[OFF_W-1:0];
    assign last_word = (ptr_reg == PW'(NW - 1));
    assign lo_mask = (WORD_W'(1) << off_reg) - WORD_W'(1);

    // scan view: padding and slots below the cursor count as used
    always_comb begin
        eff = w_raw;
        if (last_word) begin
            eff = eff | PAD_MASK;
        end
        if (cluster_reg && first_reg) begin
            eff = eff | lo_mask;
        end
    end

    // first free slot in the word
    always_comb begin
        ff = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!eff[i]) begin
                ff = OFF_W'(i);
            end
        end
    end

    assign slot_w = (CW'(ptr_reg) << OFF_W) | CW'(ff);

    // status to controller
    always_comb begin
        sts.req_type = req_type_reg;
        sts.range_bad = (32'(slot_index_reg) >= 32'(SLOT_COUNT));
        sts.count_zero = (count_reg == '0);
        sts.cluster_ok = (budget_reg != 8'd0) && (cursor_reg < CW'(SLOT_COUNT));
        sts.bit_used = w_raw[idx_off];
        sts.hit = ~&eff;
        sts.last_word = last_word;
        sts.is_cluster = cluster_reg;
        sts.out_free = !m_valid_reg || m_ready;
    end

    // bitmap memory access
    assign ram_re = cmd.rd_en;
    assign ram_raddr = ptr_reg;
    assign ram_waddr = ptr_reg;
    assign ram_we = cmd.commit_alloc || cmd.commit_free;
    assign ram_wdata = cmd.commit_alloc ? (w_raw | (WORD_W'(1) << ff))
                                        : (w_raw & ~(WORD_W'(1) << idx_off));

    // request and scan position
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg <= s_data.req_type;
            slot_index_reg <= s_data.slot_index;
        end
        if (cmd.start_idx) begin
            ptr_reg <= PW'(slot_index_reg >> OFF_W);
        end else if (cmd.start_cluster) begin
            ptr_reg <= PW'(cursor_reg >> OFF_W);
            off_reg <= cursor_reg[OFF_W-1:0];
            cluster_reg <= 1'b1;
            first_reg <= 1'b1;
        end else if (cmd.start_fresh) begin
            ptr_reg <= '0;
            off_reg <= '0;
            cluster_reg <= 1'b0;
            first_reg <= 1'b1;
        end else if (cmd.next_word) begin
            ptr_reg <= ptr_reg + PW'(1);
            first_reg <= 1'b0;
        end
        if (cmd.rd_en) begin
            row_valid_q_reg <= row_valid_reg[ptr_reg];
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            res_slot_reg <= cmd.commit_alloc ? 7'(slot_w) : 7'd0;
        end
    end

    // allocator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            count_reg <= CW'(SLOT_COUNT);
            cursor_reg <= '0;
            budget_reg <= CLUSTER_RESET;
            length_reg <= CLUSTER_RESET;
        end else begin
            if (cfg_wr_en) begin
                length_reg <= cfg_wr_data;
            end
            if (ram_we) begin
                row_valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.start_fresh) begin
                budget_reg <= length_reg;
            end
            if (cmd.cluster_fail) begin
                cursor_reg <= CW'(SLOT_COUNT);
            end
            if (cmd.commit_free) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.commit_alloc) begin
                count_reg <= count_reg - CW'(1);
                if (cluster_reg) begin
                    cursor_reg <= slot_w + CW'(1);
                    budget_reg <= budget_reg - 8'd1;
                end else begin
                    cursor_reg <= slot_w;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg.status <= res_status_reg;
            m_data_reg.granted_slot <= res_slot_reg;
            m_data_reg.free_slots <= 8'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

/* rtl/swap_slot_bitmap_allocator.sv */
// An accepted beat is decoded; unused codes, out-of-range and full-map requests go
// straight to the result. Free, check and allocate read their bitmap word and then test it.
// An allocate that misses moves on to the next 32-slot word, one read of the bitmap RAM and
// one test per word, until it hits or runs out of words. Only one item is in flight, so a
// new beat is taken only once the result of the last one has been pushed to the output.
// Reset (aresetn, synchronous, active low) frees all slots at once through per-word valid bits.
module swap_slot_bitmap_allocator #(
    parameter int SLOT_COUNT = sbsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbsa_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbsa_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    import sbsa_pkg::*;

    localparam int NW = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int PW = (NW > 1) ? $clog2(NW) : 1;

    cmd_t              cmd;
    sts_t              sts;
    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // sequencer
    sbsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // counters, cursor, scan logic and output register
    sbsa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // used-slot bitmap, one 32-bit word per row
    sbsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
